/* rtl/kmce_pkg.sv */
// Package with types, constants and helpers of the k-means clustering engine.
package kmce_pkg;

  localparam int MaxPatternsDefault = 1024;
  localparam int MaxDimsDefault     = 8;
  localparam int MaxClustersDefault = 8;

  localparam logic [2:0] RegNumClusters = 3'd0;
  localparam logic [2:0] RegVectorDims  = 3'd1;
  localparam logic [2:0] RegMaxPasses   = 3'd2;
  localparam logic [2:0] RegInitOffset  = 3'd3;
  localparam logic [2:0] RegInitStep    = 3'd4;

  typedef struct packed {
    logic signed [31:0] element_value;
    logic               last_element;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         cluster_index;
    logic [2:0]         dim_index;
    logic signed [31:0] center_value;
    logic [10:0]        member_count;
    logic [7:0]         passes_run;
    logic               converged;
    logic               overflow;
    logic               last_result;
  } out_req_t;

  typedef enum logic [3:0] {
    StLoad,
    StInit,
    StPassStart,
    StDist,
    StDistWait,
    StAcc,
    StAccWrite,
    StUpdStart,
    StDiv,
    StUpdWrite,
    StPassEnd,
    StReport,
    StReportWait,
    StClear
  } state_t;

  typedef struct packed {
    logic              start;
    logic signed [47:0] dividend;
    logic [10:0]       divisor;
  } div_req_t;

endpackage

/* rtl/kmeans_clustering_engine_core.sv */
// K-means clustering engine: pattern memory, center/sum memories and pass sequencer.
// Loading: one element per cycle, in_ready high only while loading.
// Clustering: center init; each pass clears sums and counts, assigns each pattern to its
//   nearest center, divides each sum by its count (skipped if empty) and ends the pass.
// Report: one result per center coordinate; the last element request starts clustering.
// Reset (rst, synchronous) clears control state; pattern memory is not cleared.
module kmeans_clustering_engine_core #(
  parameter int MAX_PATTERNS = kmce_pkg::MaxPatternsDefault,
  parameter int MAX_DIMS     = kmce_pkg::MaxDimsDefault,
  parameter int MAX_CLUSTERS = kmce_pkg::MaxClustersDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  kmce_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kmce_pkg::out_req_t out_data
);
  import kmce_pkg::*;

  localparam int PW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int CW = $clog2(MAX_PATTERNS + 1);
  localparam int PDEPTH = MAX_PATTERNS * 8;
  localparam int PAW = PW + 3;

  logic [3:0]         num_clusters;
  logic [3:0]         vector_dims;
  logic [7:0]         max_passes;
  logic signed [31:0] init_offset;
  logic signed [31:0] init_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= 4'd3;
      vector_dims  <= 4'd2;
      max_passes   <= 8'd64;
      init_offset  <= 32'sd26214;
      init_step    <= 32'sd26214;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegNumClusters: num_clusters <= cfg_data[3:0];
        RegVectorDims:  vector_dims  <= cfg_data[3:0];
        RegMaxPasses:   max_passes   <= cfg_data[7:0];
        RegInitOffset:  init_offset  <= cfg_data;
        RegInitStep:    init_step    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [3:0] k_eff;
  logic [3:0] d_eff;
  logic [7:0] cap;
  always_comb begin
    k_eff = (num_clusters == 4'd0) ? 4'd1 : num_clusters;
    if (k_eff > 4'(MAX_CLUSTERS)) k_eff = 4'(MAX_CLUSTERS);
    d_eff = (vector_dims == 4'd0) ? 4'd1 : vector_dims;
    if (d_eff > 4'(MAX_DIMS)) d_eff = 4'(MAX_DIMS);
    cap = (max_passes == 8'd0) ? 8'd1 : max_passes;
  end

  // memories
  logic signed [31:0] pmem [PDEPTH];
  logic signed [31:0] cmem [64];
  logic signed [47:0] smem [64];
  logic [10:0]        counts [8];

  logic               p_we;
  logic [PAW-1:0]     p_waddr;
  logic signed [31:0] p_wdata;
  logic [PAW-1:0]     p_raddr;
  logic signed [31:0] p_rdata;
  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= p_wdata;
    p_rdata <= pmem[p_raddr];
  end

  logic               c_we;
  logic [5:0]         c_waddr;
  logic signed [31:0] c_wdata;
  logic [5:0]         c_raddr;
  logic signed [31:0] c_rdata;
  always_ff @(posedge clk) begin
    if (c_we) cmem[c_waddr] <= c_wdata;
    c_rdata <= cmem[c_raddr];
  end

  logic               s_we;
  logic [5:0]         s_waddr;
  logic signed [47:0] s_wdata;
  logic [5:0]         s_raddr;
  logic signed [47:0] s_rdata;
  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr] <= s_wdata;
    s_rdata <= smem[s_raddr];
  end

  state_t state, state_next;
  logic [CW-1:0] pcount;
  logic [2:0]    epos;
  logic          drop;
  logic [CW-1:0] p;
  logic [2:0]    c;
  logic [3:0]    d;
  logic [2:0]    best;
  logic [63:0]   best_d;
  logic [63:0]   acc;
  logic [7:0]    passes;
  logic          stable;
  logic          sq_valid;
  logic [63:0]   sq;
  logic signed [31:0] cur_center;
  logic [6:0]    clr;
  logic          div_pend;
  div_req_t      dreq;
  logic          ddone;
  logic signed [31:0] dq;
  logic signed [31:0] init_val;
  logic signed [63:0] init_full;

  kmce_divider u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quotient(dq));

  logic signed [63:0] step_prod;
  assign step_prod = 64'(init_step) * 64'(signed'({1'b0, c}));
  always_comb begin
    init_full = 64'(init_offset) + step_prod;
    if (init_full > 64'sd2147483647) init_val = 32'sh7fffffff;
    else if (init_full < -64'sd2147483648) init_val = 32'sh80000000;
    else init_val = init_full[31:0];
  end

  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [64:0]        acc_sum;
  assign diff = 33'(c_rdata) - 33'(p_rdata);
  assign mag = diff[32] ? 33'(-diff) : diff;
  assign acc_sum = 65'(acc) + 65'(sq);

  logic last_c;
  logic last_d;
  assign last_c = (4'(c) + 4'd1 >= k_eff);
  assign last_d = (d + 4'd1 >= d_eff);

  always_ff @(posedge clk) begin
    if (rst) state <= StLoad;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = (state == StLoad);
    p_we = 1'b0; p_waddr = {pcount[PW-1:0], epos}; p_wdata = in_data.element_value;
    p_raddr = {p[PW-1:0], d[2:0]};
    c_we = 1'b0; c_waddr = {c, d[2:0]}; c_wdata = init_val;
    c_raddr = {c, d[2:0]};
    s_we = 1'b0; s_waddr = {c, d[2:0]}; s_wdata = '0;
    s_raddr = {c, d[2:0]};
    dreq.start = 1'b0; dreq.dividend = s_rdata; dreq.divisor = counts[c];
    unique case (state)
      StLoad: begin
        p_we = in_valid && (pcount < CW'(MAX_PATTERNS));
        if (in_valid && in_data.last_element) state_next = StInit;
      end
      StInit: begin
        c_we = 1'b1;
        if (last_d && last_c) state_next = StPassStart;
      end
      StPassStart: begin
        s_we = 1'b1; s_waddr = clr[5:0];
        if (clr == 7'd63) state_next = (pcount == '0) ? StUpdStart : StDist;
      end
      StDist: begin
        state_next = StDistWait;
      end
      StDistWait: begin
        if (last_d) state_next = StAcc;
        else state_next = StDist;
      end
      StAcc: begin
        s_raddr = {best, d[2:0]};
        if (div_pend) state_next = StAccWrite;
        else if (!last_c) state_next = StDist;
      end
      StAccWrite: begin
        s_we = 1'b1; s_waddr = {best, d[2:0]};
        s_wdata = s_rdata + 48'(p_rdata);
        if (last_d) state_next = (p + CW'(1) >= pcount) ? StUpdStart : StDist;
        else state_next = StAcc;
      end
      StUpdStart: begin
        state_next = StDiv;
      end
      StDiv: begin
        dreq.start = div_pend && (counts[c] != 11'd0);
        if (counts[c] == 11'd0) state_next = StUpdWrite;
        else if (ddone) state_next = StUpdWrite;
      end
      StUpdWrite: begin
        c_we = (counts[c] != 11'd0); c_wdata = dq;
        if (last_d && last_c) state_next = StPassEnd;
        else state_next = StUpdStart;
      end
      StPassEnd: begin
        if (stable || passes >= cap) state_next = StReport;
        else state_next = StPassStart;
      end
      StReport: begin
        state_next = StReportWait;
      end
      StReportWait: begin
        if (out_valid && out_ready && last_d && last_c) state_next = StClear;
        else if (out_valid && out_ready) state_next = StReport;
      end
      StClear: state_next = StLoad;
      default: state_next = StLoad;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= '0; epos <= '0; drop <= 1'b0;
      c <= '0; d <= '0; p <= '0; clr <= '0; passes <= '0;
      sq_valid <= 1'b0; div_pend <= 1'b0; out_valid <= 1'b0;
    end else begin
      unique case (state)
        StLoad: begin
          if (in_valid) begin
            if (pcount >= CW'(MAX_PATTERNS)) drop <= 1'b1;
            if (4'(epos) + 4'd1 >= d_eff) begin
              epos <= '0;
              if (pcount < CW'(MAX_PATTERNS)) pcount <= pcount + CW'(1);
            end else epos <= epos + 3'd1;
            c <= '0; d <= '0; passes <= '0;
          end
        end
        StInit: begin
          if (last_d) begin d <= '0; c <= c + 3'd1; end
          else d <= d + 4'd1;
          clr <= '0;
        end
        StPassStart: begin
          clr <= clr + 7'd1;
          if (clr == 7'd0) begin
            for (int i = 0; i < 8; i++) counts[i] <= '0;
            passes <= passes + 8'd1; stable <= 1'b1;
          end
          p <= '0; c <= '0; d <= '0; acc <= '0;
          best <= '0; best_d <= '1;
          div_pend <= 1'b0;
        end
        StDist: ;
        StDistWait: begin
          sq <= 64'(mag) * 64'(mag);
          sq_valid <= 1'b1;
          d <= last_d ? 4'd0 : d + 4'd1;
        end
        default: ;
      endcase
      if (sq_valid && state != StDistWait) begin
        sq_valid <= 1'b0;
        if (state == StDist) begin
          if (acc_sum[64]) acc <= '1; else acc <= acc_sum[63:0];
        end
      end
      if (state == StAcc && !div_pend) begin
        if (sq_valid) begin
          if (acc_sum[64] ? 1'b0 : ((c == 3'd0) || acc_sum[63:0] < best_d)) begin
            best <= c; best_d <= acc_sum[63:0];
          end else if (acc_sum[64] && c == 3'd0) begin
            best <= c; best_d <= '1;
          end
        end
        acc <= '0;
        if (last_c) begin
          div_pend <= 1'b1; d <= '0;
        end else begin
          c <= c + 3'd1;
        end
      end
      if (state == StAccWrite) begin
        if (last_d) begin
          counts[best] <= counts[best] + 11'd1;
          div_pend <= 1'b0; d <= '0; c <= '0; p <= p + CW'(1);
          best <= '0; best_d <= '1;
        end else d <= d + 4'd1;
      end
      if (state == StUpdStart) div_pend <= 1'b1;
      if (state == StDiv) begin
        div_pend <= 1'b0;
        cur_center <= c_rdata;
      end
      if (state == StUpdWrite) begin
        if (counts[c] != 11'd0 && dq != cur_center) stable <= 1'b0;
        if (last_d) begin d <= '0; c <= c + 3'd1; end
        else d <= d + 4'd1;
      end
      if (state == StPassEnd) begin
        c <= '0; d <= '0; clr <= '0;
      end
      if (state == StReport) begin
        out_valid <= 1'b0;
      end
      if (state == StReportWait && !out_valid) begin
        out_valid <= 1'b1;
        out_data.cluster_index <= c;
        out_data.dim_index <= d[2:0];
        out_data.center_value <= c_rdata;
        out_data.member_count <= counts[c];
        out_data.passes_run <= passes;
        out_data.converged <= stable;
        out_data.overflow <= drop;
        out_data.last_result <= last_d && last_c;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
        if (last_d) begin d <= '0; c <= c + 3'd1; end
        else d <= d + 4'd1;
      end
      if (state == StClear) begin
        pcount <= '0; epos <= '0; drop <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("input open during report");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> passes != 8'd0)
    else $error("report before any pass");
  assert property (@(posedge clk) disable iff (rst) (state == StPassEnd) |-> passes <= cap)
    else $error("pass cap exceeded");
endmodule

/* rtl/kmce_divider.sv */
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
module kmce_divider (
  input  logic              clk,
  input  logic              rst,
  input  kmce_pkg::div_req_t req,
  output logic              done,
  output logic signed [31:0] quotient
);
  import kmce_pkg::*;

  logic [47:0] rem_mag;
  logic [47:0] quo;
  logic [10:0] dsr;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [48:0] shifted;
  logic [48:0] trial;
  logic [47:0] dvd_mag;
  logic [47:0] quo_final;
  logic [47:0] rem_next;

  assign dvd_mag = req.dividend[47] ? 48'(-req.dividend) : 48'(req.dividend);
  assign shifted = {rem_next, quo[47]};
  assign rem_next = rem_mag;
  assign trial = shifted - 49'(dsr);
  assign quo_final = neg ? 48'(-quo) : quo;
  assign quotient = quo_final[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        rem_mag <= '0;
        quo     <= dvd_mag;
        dsr     <= req.divisor;
        neg     <= req.dividend[47];
        cnt     <= 6'd48;
      end else if (busy) begin
        if (!trial[48]) begin
          rem_mag <= trial[47:0];
          quo     <= {quo[46:0], 1'b1};
        end else begin
          rem_mag <= shifted[47:0];
          quo     <= {quo[46:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
